// File: rtl/core/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ttpu_pkg.sv
`default_nettype none
package ttpu_pkg;

  typedef enum logic [1:0] {
    KIND_MEM = 2'd0,
    KIND_R   = 2'd1,
    KIND_D   = 2'd2,
    KIND_S   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_GET   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_t;

  // Decoded command
  typedef struct packed {
    logic       direct;
    logic       valid_op;
    op_t        op;
    kind_t      src;
    kind_t      dst;
    logic [3:0] width;
    logic       add;
    logic       guard;
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;
    logic load;
    logic rd_mem;
    logic rd_reg;
    logic wr_mem;
    logic wr_reg;
    logic step_rst;
    logic step;
    logic finish;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic step_last;
    logic phase;
    logic src_mem;
    logic dst_mem;
    logic skip;
    logic noop;
  } sts_t;

  localparam logic [5:0] FUNC_FIRST_MOVE = 6'd14;
  localparam logic [5:0] FUNC_END        = 6'd38;

  function automatic cmd_t decode(input logic [5:0] f);
    cmd_t c;
    c = '0;
    c.valid_op = (f < FUNC_END);
    if (f < 6'd4) begin
      c.direct = 1'b1; c.dst = KIND_MEM; c.op = op_t'(f[1:0]);
    end else if (f < 6'd8) begin
      c.direct = 1'b1; c.dst = KIND_R; c.op = op_t'(f[1:0]);
    end else if (f < 6'd11) begin
      c.direct = 1'b1; c.dst = KIND_D; c.op = op_t'(2'(f - 6'd7));
    end else if (f < FUNC_FIRST_MOVE) begin
      c.direct = 1'b1; c.dst = KIND_S; c.op = op_t'(2'(f - 6'd10));
    end else begin
      c.op = OP_SET;
      unique case (f)
        6'd14: begin c.src = KIND_MEM; c.dst = KIND_R; c.width = 4'd1; c.add = 1'b1; end
        6'd15: begin c.src = KIND_MEM; c.dst = KIND_R; c.width = 4'd1; end
        6'd16: begin c.src = KIND_MEM; c.dst = KIND_R; c.width = 4'd4; c.add = 1'b1; end
        6'd17: begin c.src = KIND_MEM; c.dst = KIND_R; c.width = 4'd4; end
        6'd18: begin c.src = KIND_MEM; c.dst = KIND_R; c.width = 4'd2; end
        6'd19: begin c.src = KIND_R; c.dst = KIND_MEM; c.width = 4'd1; c.add = 1'b1; end
        6'd20: begin c.src = KIND_R; c.dst = KIND_MEM; c.width = 4'd1; end
        6'd21: begin
          c.src = KIND_R; c.dst = KIND_MEM; c.width = 4'd4; c.add = 1'b1; c.guard = 1'b1;
        end
        6'd22: begin c.src = KIND_R; c.dst = KIND_MEM; c.width = 4'd4; c.guard = 1'b1; end
        6'd23: begin c.src = KIND_R; c.dst = KIND_MEM; c.width = 4'd2; c.guard = 1'b1; end
        6'd24: begin c.src = KIND_R; c.dst = KIND_R; c.width = 4'd1; c.add = 1'b1; end
        6'd25: begin c.src = KIND_R; c.dst = KIND_R; c.width = 4'd1; end
        6'd26: begin c.src = KIND_MEM; c.dst = KIND_D; c.width = 4'd8; end
        6'd27: begin c.src = KIND_D; c.dst = KIND_MEM; c.width = 4'd8; c.guard = 1'b1; end
        6'd28: begin c.src = KIND_D; c.dst = KIND_R; c.width = 4'd1; end
        6'd29: begin c.src = KIND_R; c.dst = KIND_D; c.width = 4'd1; end
        6'd30: begin c.src = KIND_D; c.dst = KIND_D; c.width = 4'd1; end
        6'd31: begin c.src = KIND_D; c.dst = KIND_S; c.width = 4'd1; end
        6'd32: begin c.src = KIND_MEM; c.dst = KIND_S; c.width = 4'd4; end
        6'd33: begin c.src = KIND_S; c.dst = KIND_MEM; c.width = 4'd4; c.guard = 1'b1; end
        6'd34: begin c.src = KIND_S; c.dst = KIND_R; c.width = 4'd1; end
        6'd35: begin c.src = KIND_R; c.dst = KIND_S; c.width = 4'd1; end
        6'd36: begin c.src = KIND_S; c.dst = KIND_S; c.width = 4'd1; end
        6'd37: begin c.src = KIND_S; c.dst = KIND_D; c.width = 4'd1; end
        default: c.valid_op = 1'b0;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ttpu_ctrl.sv
`default_nettype none
module ttpu_ctrl
  import ttpu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Clear after reset, then sequence one transaction: read pass, then write pass, or skip both
  always_comb begin
    state_next = state;
    ctl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ctl.clr_en = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (sts.noop || sts.skip) begin
          ctl.finish = 1'b1;
          state_next = ST_DONE;
        end else if (sts.src_mem) begin
          ctl.rd_mem = 1'b1;
          ctl.step = 1'b1;
          if (sts.step_last && sts.phase) begin
            ctl.step_rst = 1'b1;
            state_next = ST_WRITE;
          end
        end else begin
          ctl.rd_reg = 1'b1;
          ctl.step_rst = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (sts.dst_mem) begin
          ctl.wr_mem = 1'b1;
          ctl.step = 1'b1;
          if (sts.step_last && sts.phase) begin
            ctl.finish = 1'b1;
            state_next = ST_DONE;
          end
        end else begin
          ctl.wr_reg = 1'b1;
          ctl.finish = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/ttpu_dpath.sv
`default_nettype none
module ttpu_dpath
  import ttpu_pkg::*;
#(
  parameter int TAG_MEM_BYTES = 4096,
  parameter int NUM_CORE_REGS = 16,
  parameter int NUM_SINGLE_REGS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctl_t        ctl,
  output sts_t             sts,
  input  wire logic [5:0]  func,
  input  wire logic [11:0] address,
  input  wire logic [4:0]  first_index,
  input  wire logic [4:0]  second_index,
  input  wire logic [31:0] tag_value,
  output logic [31:0]      tag_out,
  output logic             hit,
  output logic             rejected
);

  localparam int AW = $clog2(TAG_MEM_BYTES);
  localparam int RW = $clog2(NUM_CORE_REGS);
  localparam int SW = $clog2(NUM_SINGLE_REGS);
  localparam int NUM_DOUBLE_REGS = 16;
  localparam int DW = $clog2(NUM_DOUBLE_REGS);

  logic [31:0] mem [TAG_MEM_BYTES];
  logic [31:0] rreg [NUM_CORE_REGS];
  logic [31:0] dreg [NUM_DOUBLE_REGS];
  logic [31:0] sreg [NUM_SINGLE_REGS];

  cmd_t        cmd;
  logic [11:0] addr_q;
  logic [4:0]  fi_q, si_q;
  logic [31:0] tv_q;
  logic [31:0] acc;
  logic [AW-1:0] clr_ptr;
  logic [3:0]  step_cnt;
  logic        phase;
  logic [31:0] mem_q;
  logic        mem_q_ok;

  // Byte address of current step, unwrapped
  logic [12:0] byte_addr;
  logic        byte_ok;
  assign byte_addr = {1'b0, addr_q} + 13'(step_cnt);
  assign byte_ok   = 32'(byte_addr) < TAG_MEM_BYTES;

  function automatic logic idx_ok(input kind_t k, input logic [4:0] i);
    unique case (k)
      KIND_R:  idx_ok = 32'(i) < NUM_CORE_REGS;
      KIND_D:  idx_ok = 32'(i) < NUM_DOUBLE_REGS;
      KIND_S:  idx_ok = 32'(i) < NUM_SINGLE_REGS;
      default: idx_ok = 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] reg_rd(input kind_t k, input logic [4:0] i,
                                         input logic [31:0] r, input logic [31:0] d,
                                         input logic [31:0] s);
    if (!idx_ok(k, i)) reg_rd = '0;
    else begin
      unique case (k)
        KIND_R:  reg_rd = r;
        KIND_D:  reg_rd = d;
        default: reg_rd = s;
      endcase
    end
  endfunction

  // Register indices and read ports
  kind_t       rk, wk;
  logic [4:0]  ri, wi;
  logic [31:0] rsel;
  logic [31:0] rv_r, rv_d, rv_s;
  assign rk = cmd.direct ? cmd.dst : cmd.src;
  assign ri = cmd.direct ? fi_q : ((cmd.dst == KIND_MEM || cmd.src == KIND_MEM) ? fi_q : si_q);
  assign wk = cmd.dst;
  assign wi = fi_q;
  assign rv_r = rreg[ri[RW-1:0]];
  assign rv_d = dreg[ri[DW-1:0]];
  assign rv_s = sreg[ri[SW-1:0]];
  assign rsel = reg_rd(rk, ri, rv_r, rv_d, rv_s);

  logic [31:0] old_w;
  assign old_w = reg_rd(wk, wi, rreg[wi[RW-1:0]], dreg[wi[DW-1:0]], sreg[wi[SW-1:0]]);

  // Status to controller
  logic [3:0] width_eff;
  assign width_eff = cmd.direct ? 4'd1 : cmd.width;
  always_comb begin
    sts = '0;
    sts.clr_last  = (clr_ptr == AW'(TAG_MEM_BYTES - 1));
    sts.src_mem   = cmd.direct ? (cmd.dst == KIND_MEM) : (cmd.src == KIND_MEM);
    sts.dst_mem   = (cmd.dst == KIND_MEM);
    sts.noop      = !cmd.valid_op || (cmd.direct && cmd.op != OP_GET && cmd.op != OP_CLEAR
                    && tv_q == '0);
    sts.skip      = !cmd.direct && cmd.guard && !idx_ok(cmd.src, fi_q);
    sts.step_last = (step_cnt == 4'(width_eff - 4'd1));
    sts.phase     = phase;
  end

  // Memory read data registered
  always_ff @(posedge clk) begin
    mem_q <= mem[AW'(byte_addr)];
    mem_q_ok <= byte_ok;
  end

  logic [31:0] mem_rd;
  assign mem_rd = mem_q_ok ? mem_q : '0;

  // Value to store for the current write step
  logic [31:0] src_val, wdata;
  always_comb begin
    if (cmd.direct) begin
      unique case (cmd.op)
        OP_ADD:  src_val = tv_q;
        OP_SET:  src_val = tv_q;
        default: src_val = '0;
      endcase
    end else src_val = acc;
  end

  // Merge with the old memory word for OR
  logic [31:0] mem_old_cur;
  assign mem_old_cur = mem_rd;
  always_comb begin
    if (cmd.direct && cmd.op == OP_ADD) wdata = mem_old_cur | src_val;
    else if (!cmd.direct && cmd.add)    wdata = mem_old_cur | src_val;
    else                                wdata = src_val;
  end

  // Memory write and clearing pass; a direct get never writes
  always_ff @(posedge clk) begin
    if (ctl.clr_en) mem[clr_ptr] <= '0;
    else if (ctl.wr_mem && phase && byte_ok && !(cmd.direct && cmd.op == OP_GET))
      mem[AW'(byte_addr)] <= wdata;
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
      step_cnt <= '0;
      phase <= 1'b0;
      for (int i = 0; i < NUM_CORE_REGS; i++) rreg[i] <= '0;
      for (int i = 0; i < NUM_DOUBLE_REGS; i++) dreg[i] <= '0;
      for (int i = 0; i < NUM_SINGLE_REGS; i++) sreg[i] <= '0;
    end else begin
      if (ctl.clr_en) clr_ptr <= clr_ptr + AW'(1);
      if (ctl.load) begin
        cmd <= decode(func);
        addr_q <= address;
        fi_q <= first_index;
        si_q <= second_index;
        tv_q <= tag_value;
        acc <= '0;
        step_cnt <= '0;
        phase <= 1'b0;
        tag_out <= '0; hit <= 1'b0; rejected <= 1'b0;
      end
      // Step through bytes: address in phase 0, data in phase 1
      if (ctl.step_rst) begin
        step_cnt <= '0;
        phase <= 1'b0;
      end else if (ctl.rd_mem || ctl.wr_mem) begin
        phase <= !phase;
        if (phase) step_cnt <= step_cnt + 4'd1;
      end
      // Fold read data, or take the register source
      if (ctl.rd_mem && phase) acc <= acc | mem_rd;
      if (ctl.rd_reg) acc <= rsel;
      if (ctl.wr_reg && idx_ok(wk, wi) && !(cmd.direct && cmd.op == OP_GET)) begin
        logic [31:0] v;
        v = (cmd.direct ? (cmd.op == OP_ADD) : cmd.add) ? (old_w | src_val) : src_val;
        unique case (wk)
          KIND_R:  rreg[wi[RW-1:0]] <= v;
          KIND_D:  dreg[wi[DW-1:0]] <= v;
          KIND_S:  sreg[wi[SW-1:0]] <= v;
          default: ;
        endcase
      end
      if (ctl.finish) begin
        if (!cmd.valid_op || sts.skip) begin
          tag_out <= '0; hit <= 1'b0; rejected <= 1'b0;
        end else if (sts.noop) begin
          rejected <= 1'b1;
        end else if (cmd.direct) begin
          unique case (cmd.op)
            OP_GET: begin
              tag_out <= (cmd.dst == KIND_MEM) ? acc : old_w;
              hit <= ((cmd.dst == KIND_MEM) ? acc : old_w) != '0;
            end
            OP_CLEAR: hit <= ((cmd.dst == KIND_MEM) ? acc : old_w) != '0;
            default: begin
              tag_out <= tv_q;
              hit <= ((cmd.dst == KIND_MEM) ? acc : old_w) != '0;
            end
          endcase
        end else begin
          tag_out <= acc;
          hit <= acc != '0;
        end
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_wr_in_clear, clk, rst, ctl.clr_en, !ctl.wr_mem && !ctl.load,
    "write during clearing pass")
  `ASSERT_IMPL(a_step_range, clk, rst, ctl.step, step_cnt < 4'd8, "step count overrun")
  `ASSERT_NEXT(a_load_clears, clk, rst, ctl.load, !rejected && !hit, "result not cleared")

endmodule
`default_nettype wire

// File: rtl/core/taint_tag_propagation_unit.sv
`default_nettype none
// channel | direction | handshake       | payload
// in      | input     | valid / ready   | func address first_index second_index tag_value
// out     | output    | valid / ready   | tag_out hit rejected
// One command at a time; a register-only command passes a read and a write state,
// while rejected, unused and guarded-off commands go from read straight to done.
// Memory commands step through each byte read and each byte written, with an address
// phase and a data phase each, on the single tag memory port; moves span up to 8 bytes.
// After reset a clearing pass zeroes every tag memory entry; in_ready is low meanwhile.
// A result waits in its output register until out_ready.
module taint_tag_propagation_unit
  import ttpu_pkg::*;
#(
  parameter int TAG_MEM_BYTES = 4096,
  parameter int NUM_CORE_REGS = 16,
  parameter int NUM_SINGLE_REGS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [5:0]  func,
  input  wire logic [11:0] address,
  input  wire logic [4:0]  first_index,
  input  wire logic [4:0]  second_index,
  input  wire logic [31:0] tag_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      tag_out,
  output logic             hit,
  output logic             rejected
);

  ctl_t ctl;
  sts_t sts;

  ttpu_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .ctl
  );

  ttpu_dpath #(
    .TAG_MEM_BYTES(TAG_MEM_BYTES),
    .NUM_CORE_REGS(NUM_CORE_REGS),
    .NUM_SINGLE_REGS(NUM_SINGLE_REGS)
  ) u_dpath (
    .clk, .rst, .ctl, .sts, .func, .address, .first_index, .second_index,
    .tag_value, .tag_out, .hit, .rejected
  );

endmodule
`default_nettype wire
